// ===== hw/rtl/nlhl_pkg.sv =====
// ----------------------------------------------------------------------------
// nlhl_pkg
// Shared widths, constants, types and hinge-term helpers for the noisy-label
// hinge cost core.
// ----------------------------------------------------------------------------
package nlhl_pkg;

  localparam int unsigned SCORE_W     = 16;
  localparam int unsigned TERM_W      = 17;  // one item term plus held top term
  localparam int unsigned ROW_COST_W  = 26;
  localparam int unsigned ROWS_W      = 17;
  localparam int unsigned BATCH_W     = 42;
  localparam int unsigned DIV_CNT_W   = $clog2(BATCH_W);

  localparam int signed   ONE_Q12      = 4096;
  localparam int unsigned ROW_COST_MAX = 37748736;
  localparam int unsigned COUNTER_MAX  = 131071;
  localparam int unsigned MAX_ROWS_DEF = 65536;

  // Row queue between front and back; depth is a power of two
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One finished row handed from front to back
  typedef struct packed {
    logic [ROW_COST_W-1:0] cost;
    logic                  batch_end;
  } row_rec_t;

  // Back-end sequencer
  typedef enum logic [1:0] {
    BE_IDLE,
    BE_DIV,
    BE_OUT
  } be_state_t;

  // max(0, 1 - s) in Q4.12
  function automatic logic [TERM_W-1:0] pos_term(input logic signed [SCORE_W-1:0] s);
    logic signed [TERM_W:0] diff;
    diff = (TERM_W+1)'(ONE_Q12) - (TERM_W+1)'(s);
    return (s >= SCORE_W'(ONE_Q12)) ? '0 : diff[TERM_W-1:0];
  endfunction

  // max(0, s + 1) in Q4.12
  function automatic logic [TERM_W-1:0] neg_term(input logic signed [SCORE_W-1:0] s);
    logic signed [TERM_W:0] sum;
    sum = (TERM_W+1)'(s) + (TERM_W+1)'(ONE_Q12);
    return (s <= -SCORE_W'(ONE_Q12)) ? '0 : sum[TERM_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/nlhl_if.sv =====
// ----------------------------------------------------------------------------
// nlhl_in_if / nlhl_out_if
// Valid/ready channels for label beats in and row results out.
// ----------------------------------------------------------------------------
interface nlhl_in_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] score;
  logic        is_positive;
  logic        row_clean;
  logic        last_in_row;
  logic        last_in_batch;

  modport source (output valid, score, is_positive, row_clean, last_in_row,
                  last_in_batch, input ready);
  modport sink   (input valid, score, is_positive, row_clean, last_in_row,
                  last_in_batch, output ready);
endinterface

interface nlhl_out_if;
  logic        valid;
  logic        ready;
  logic [25:0] row_cost;
  logic        batch_done;
  logic [25:0] batch_mean;
  logic [16:0] rows_in_batch;

  modport source (output valid, row_cost, batch_done, batch_mean, rows_in_batch,
                  input ready);
  modport sink   (input valid, row_cost, batch_done, batch_mean, rows_in_batch,
                  output ready);
endinterface

// ===== hw/rtl/nlhl_front.sv =====
// ----------------------------------------------------------------------------
// nlhl_front
// Accepts label beats, classifies each label, tracks the held-back top
// positive and accumulates the row cost; pushes one record per row end.
// ----------------------------------------------------------------------------
module nlhl_front (
  input  logic                     clk,
  input  logic                     rst_n,
  nlhl_in_if.sink                  in_ch,
  input  logic                     cfg_we,
  input  logic                     cfg_data,
  input  logic [nlhl_pkg::QCNT_W-1:0] q_cnt,
  output logic                     push,
  output nlhl_pkg::row_rec_t       push_rec
);
  import nlhl_pkg::*;

  logic                      clean_mode_r;
  logic signed [SCORE_W-1:0] best_r;
  logic                      best_valid_r;

  logic                      s1_v_r;
  logic [TERM_W-1:0]         s1_term_r;
  logic                      s1_row_end_r;
  logic                      s1_batch_end_r;

  logic [ROW_COST_W-1:0]     acc_r;

  logic                      accept;
  logic                      held;
  logic                      take_best;
  logic signed [SCORE_W-1:0] best_s;
  logic                      best_v;
  logic [TERM_W-1:0]         item_term;
  logic [TERM_W-1:0]         end_term;
  logic [TERM_W:0]           add_term;
  logic [ROW_COST_W:0]       acc_sum;
  logic [ROW_COST_W-1:0]     acc_sat;
  logic [QCNT_W:0]           used;

  // Room check counts the beat sitting in stage 1 as a possible push
  assign used        = {1'b0, q_cnt} + {{QCNT_W{1'b0}}, s1_v_r};
  assign in_ch.ready = used < (QCNT_W+1)'(QUEUE_DEPTH);
  assign accept      = in_ch.valid && in_ch.ready;

  // Classify: in clean mode, positives in noisy rows are held back for the top pick
  assign held      = in_ch.is_positive && clean_mode_r && !in_ch.row_clean;
  assign take_best = held && (!best_valid_r || (in_ch.score > best_r));
  assign best_s    = take_best ? in_ch.score : best_r;
  assign best_v    = best_valid_r || held;

  always_comb begin
    if (!in_ch.is_positive) begin
      item_term = neg_term(in_ch.score);
    end else if (held) begin
      item_term = '0;
    end else begin
      item_term = pos_term(in_ch.score);
    end
  end

  assign end_term = (in_ch.last_in_row && best_v) ? pos_term(best_s) : '0;
  assign add_term = {1'b0, item_term} + {1'b0, end_term};

  // Config register and top-positive tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clean_mode_r <= 1'b0;
      best_r       <= '0;
      best_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        clean_mode_r <= cfg_data;
      end
      if (accept) begin
        if (in_ch.last_in_row) begin
          best_r       <= '0;
          best_valid_r <= 1'b0;
        end else begin
          best_r       <= best_s;
          best_valid_r <= best_v;
        end
      end
    end
  end

  // Stage 1: registered term of the beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_term_r      <= add_term[TERM_W-1:0];
      s1_row_end_r   <= in_ch.last_in_row;
      s1_batch_end_r <= in_ch.last_in_batch;
    end
  end

  // Stage 2: saturating row accumulator
  assign acc_sum = {1'b0, acc_r} + (ROW_COST_W+1)'(s1_term_r);
  assign acc_sat = (acc_sum > (ROW_COST_W+1)'(ROW_COST_MAX)) ?
                   ROW_COST_W'(ROW_COST_MAX) : acc_sum[ROW_COST_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (s1_v_r) begin
      acc_r <= s1_row_end_r ? '0 : acc_sat;
    end
  end

  assign push               = s1_v_r && s1_row_end_r;
  assign push_rec.cost      = acc_sat;
  assign push_rec.batch_end = s1_batch_end_r;

endmodule

// ===== hw/rtl/nlhl_queue.sv =====
// ----------------------------------------------------------------------------
// nlhl_queue
// Small FIFO of finished-row records between the front and the back.
// ----------------------------------------------------------------------------
module nlhl_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  nlhl_pkg::row_rec_t          push_rec,
  input  logic                        pop,
  output nlhl_pkg::row_rec_t          head_rec,
  output logic                        empty,
  output logic [nlhl_pkg::QCNT_W-1:0] count
);
  import nlhl_pkg::*;

  row_rec_t            slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;

  assign empty    = (count_r == '0);
  assign count    = count_r;
  assign head_rec = slots_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_rec;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== hw/rtl/nlhl_back.sv =====
// ----------------------------------------------------------------------------
// nlhl_back
// Batch sum and row count, radix-2 restoring divider for the batch average,
// and the output register.
// ----------------------------------------------------------------------------
module nlhl_back #(
  parameter int unsigned MAX_ROWS = nlhl_pkg::MAX_ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  nlhl_pkg::row_rec_t head_rec,
  output logic               pop,
  nlhl_out_if.source         out_ch
);
  import nlhl_pkg::*;

  localparam int unsigned ROW_LIMIT = (MAX_ROWS < COUNTER_MAX) ? MAX_ROWS : COUNTER_MAX;

  be_state_t              state_r, state_nxt;

  logic [BATCH_W-1:0]     batch_sum_r;
  logic [ROWS_W-1:0]      rows_r;

  logic [BATCH_W-1:0]     num_r;     // dividend, becomes quotient
  logic [ROWS_W-1:0]      den_r;
  logic [ROWS_W-1:0]      rem_r;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic [ROW_COST_W-1:0]  hold_cost_r;

  logic                   out_valid_r;
  logic [ROW_COST_W-1:0]  out_cost_r;
  logic                   out_done_r;
  logic [ROW_COST_W-1:0]  out_avg_r;
  logic [ROWS_W-1:0]      out_rows_r;

  logic                   out_free;
  logic                   load_row;
  logic                   load_batch;
  logic                   div_last;
  logic [BATCH_W:0]       sum_ext;
  logic [BATCH_W-1:0]     sum_sat;
  logic [ROWS_W-1:0]      rows_inc;
  logic [ROWS_W:0]        rem_sh;
  logic [ROWS_W:0]        rem_diff;
  logic                   q_bit;
  logic [ROW_COST_W-1:0]  avg_clamp;

  assign out_free = !out_valid_r || out_ch.ready;
  assign div_last = (cnt_r == DIV_CNT_W'(BATCH_W - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BE_IDLE: begin
        if (!q_empty && out_free && head_rec.batch_end) begin
          state_nxt = BE_DIV;
        end
      end
      BE_DIV: begin
        if (div_last) begin
          state_nxt = BE_OUT;
        end
      end
      BE_OUT: begin
        if (out_free) begin
          state_nxt = BE_IDLE;
        end
      end
      default: state_nxt = BE_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    pop        = 1'b0;
    load_row   = 1'b0;
    load_batch = 1'b0;
    unique case (state_r)
      BE_IDLE: begin
        pop      = !q_empty && out_free;
        load_row = pop && !head_rec.batch_end;
      end
      BE_OUT: begin
        load_batch = out_free;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Saturating batch sum and row count for the popped row
  assign sum_ext  = {1'b0, batch_sum_r} + (BATCH_W+1)'(head_rec.cost);
  assign sum_sat  = sum_ext[BATCH_W] ? '1 : sum_ext[BATCH_W-1:0];
  assign rows_inc = (rows_r < ROWS_W'(ROW_LIMIT)) ? rows_r + 1'b1 : rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_sum_r <= '0;
      rows_r      <= '0;
    end else if (pop) begin
      if (head_rec.batch_end) begin
        batch_sum_r <= '0;
        rows_r      <= '0;
      end else begin
        batch_sum_r <= sum_sat;
        rows_r      <= rows_inc;
      end
    end
  end

  // One quotient bit per cycle
  assign rem_sh   = {rem_r, num_r[BATCH_W-1]};
  assign rem_diff = rem_sh - {1'b0, den_r};
  assign q_bit    = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (pop && head_rec.batch_end) begin
      num_r       <= sum_sat;
      den_r       <= rows_inc;
      rem_r       <= '0;
      cnt_r       <= '0;
      hold_cost_r <= head_rec.cost;
    end else if (state_r == BE_DIV) begin
      num_r <= {num_r[BATCH_W-2:0], q_bit};
      rem_r <= q_bit ? rem_diff[ROWS_W-1:0] : rem_sh[ROWS_W-1:0];
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign avg_clamp = (num_r > BATCH_W'(ROW_COST_MAX)) ?
                     ROW_COST_W'(ROW_COST_MAX) : num_r[ROW_COST_W-1:0];

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_row || load_batch) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_row) begin
      out_cost_r <= head_rec.cost;
      out_done_r <= 1'b0;
      out_avg_r  <= '0;
      out_rows_r <= '0;
    end else if (load_batch) begin
      out_cost_r <= hold_cost_r;
      out_done_r <= 1'b1;
      out_avg_r  <= avg_clamp;
      out_rows_r <= den_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.row_cost      = out_cost_r;
  assign out_ch.batch_done    = out_done_r;
  assign out_ch.batch_mean    = out_avg_r;
  assign out_ch.rows_in_batch = out_rows_r;

endmodule

// ===== hw/rtl/noisy_label_hinge_loss_core.sv =====
// ----------------------------------------------------------------------------
// noisy_label_hinge_loss_core
// Streaming multilabel hinge cost with a noisy-label top-positive mode.
// ----------------------------------------------------------------------------
// Label beats are taken one per cycle while input ready is high. Each row
// end produces one result beat; rows that do not close a batch leave at one
// per cycle while the result side is ready. A row that closes a batch holds
// the back end while it pops the row, divides the 42-bit batch sum
// bit-serially by the row count and loads the output register; the 4-entry
// row queue between front and back lets label beats keep flowing meanwhile,
// and input ready drops once the queue holds three rows with a beat still in
// the term stage, or four rows. clean_mode is written via cfg_we/cfg_data;
// the user must write it only while the block is idle; nothing enforces it.
// ----------------------------------------------------------------------------
module noisy_label_hinge_loss_core #(
  parameter int unsigned MAX_ROWS = nlhl_pkg::MAX_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  nlhl_in_if.sink     in_ch,
  nlhl_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_data
);
  import nlhl_pkg::*;

  logic              push;
  row_rec_t          push_rec;
  logic              pop;
  row_rec_t          head_rec;
  logic              q_empty;
  logic [QCNT_W-1:0] q_cnt;

  // Front: classify and accumulate rows
  nlhl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_cnt    (q_cnt),
    .push     (push),
    .push_rec (push_rec)
  );

  // Row queue
  nlhl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .empty    (q_empty),
    .count    (q_cnt)
  );

  // Back: batch average and results
  nlhl_back #(
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .head_rec (head_rec),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

// ===== dv/noisy_label_hinge_loss_checker.sv =====
// ----------------------------------------------------------------------------
// noisy_label_hinge_loss_checker
// Watches the label and result channels of the hinge cost core, keeps its own
// model of the row and batch sums, and compares every result beat with the
// oldest predicted row result. Mismatches are counted for the testbench top.
// ----------------------------------------------------------------------------
module noisy_label_hinge_loss_checker (
  input  logic clk,
  input  logic rst_n,
  nlhl_in_if   in_mon,
  nlhl_out_if  out_mon,
  input  logic cfg_we,
  input  logic cfg_data,
  output int   errors,
  output int   pending
);
  import nlhl_pkg::*;

  localparam int unsigned ROWS_LIMIT =
    (MAX_ROWS_DEF < COUNTER_MAX) ? MAX_ROWS_DEF : COUNTER_MAX;

  typedef struct packed {
    logic [ROW_COST_W-1:0] row_cost;
    logic                  batch_done;
    logic [ROW_COST_W-1:0] batch_mean;
    logic [ROWS_W-1:0]     rows_in_batch;
  } row_result_t;

  // Predicted row results, oldest first
  row_result_t row_results_q[$];

  // Model state
  logic                      top_only_mode;
  logic [ROW_COST_W-1:0]     row_sum;
  logic signed [SCORE_W-1:0] top_score;
  logic                      top_seen;
  logic [BATCH_W-1:0]        batch_sum;
  logic [ROWS_W-1:0]         rows_done;

  // Hinge term of one label: max(0, 1 - s) for a positive, max(0, s + 1) else
  function automatic int unsigned hinge_term(input logic signed [SCORE_W-1:0] s,
                                             input logic positive);
    int v;
    v = positive ? ONE_Q12 - int'(s) : int'(s) + ONE_Q12;
    return (v > 0) ? v : 0;
  endfunction

  // Saturating add into the row sum
  task automatic add_to_row(input int unsigned t);
    longint unsigned sum;
    sum = longint'(row_sum) + t;
    row_sum = (sum > ROW_COST_MAX) ? ROW_COST_W'(ROW_COST_MAX) : sum[ROW_COST_W-1:0];
  endtask

  task automatic report(input string what, input longint unsigned got,
                        input longint unsigned want);
    $display("ERROR @%0t: %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Advance the model by one label beat; a row end queues one result
  task automatic predict_label(input logic signed [SCORE_W-1:0] s,
                               input logic positive, clean, row_end, batch_end);
    row_result_t     r;
    logic [BATCH_W:0] bsum;
    longint unsigned avg;
    if (!positive) begin
      add_to_row(hinge_term(s, 1'b0));
    end else if (top_only_mode && !clean) begin
      // held back: keep only the first highest positive
      if (!top_seen || s > top_score) begin
        top_score = s;
        top_seen  = 1'b1;
      end
    end else begin
      add_to_row(hinge_term(s, 1'b1));
    end

    if (row_end) begin
      if (top_seen) add_to_row(hinge_term(top_score, 1'b1));
      bsum      = {1'b0, batch_sum} + (BATCH_W+1)'(row_sum);
      batch_sum = bsum[BATCH_W] ? '1 : bsum[BATCH_W-1:0];
      if (rows_done < ROWS_LIMIT) rows_done++;

      r.row_cost      = row_sum;
      r.batch_done    = batch_end;
      r.batch_mean    = '0;
      r.rows_in_batch = '0;
      if (batch_end) begin
        avg = longint'(batch_sum) / longint'(rows_done);
        r.batch_mean    = (avg > ROW_COST_MAX) ? ROW_COST_W'(ROW_COST_MAX)
                                               : avg[ROW_COST_W-1:0];
        r.rows_in_batch = rows_done;
        batch_sum = '0;
        rows_done = '0;
      end
      row_sum   = '0;
      top_score = '0;
      top_seen  = 1'b0;
      row_results_q.insert(row_results_q.size(), r);
    end
  endtask

  always @(posedge clk) begin
    row_result_t want;
    if (!rst_n) begin
      row_results_q.delete();
      top_only_mode = 1'b0;
      row_sum       = '0;
      top_score     = '0;
      top_seen      = 1'b0;
      batch_sum     = '0;
      rows_done     = '0;
      errors        = 0;
    end else begin
      // result beat against the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (row_results_q.size() == 0) begin
          report("result beat with no row pending", 64'(out_mon.row_cost), 0);
        end else begin
          want = row_results_q.pop_front();
          if (out_mon.row_cost !== want.row_cost)
            report("row_cost", 64'(out_mon.row_cost), 64'(want.row_cost));
          if (out_mon.batch_done !== want.batch_done)
            report("batch_done", 64'(out_mon.batch_done), 64'(want.batch_done));
          if (out_mon.batch_mean !== want.batch_mean)
            report("batch_mean", 64'(out_mon.batch_mean), 64'(want.batch_mean));
          if (out_mon.rows_in_batch !== want.rows_in_batch)
            report("rows_in_batch", 64'(out_mon.rows_in_batch),
                   64'(want.rows_in_batch));
        end
      end

      if (in_mon.valid && in_mon.ready)
        predict_label(in_mon.score, in_mon.is_positive, in_mon.row_clean,
                      in_mon.last_in_row, in_mon.last_in_batch);

      // register write takes effect for later beats
      if (cfg_we) top_only_mode = cfg_data;
    end
    pending <= row_results_q.size();
  end

endmodule

// ===== dv/noisy_label_hinge_loss_core_tb.sv =====
// ----------------------------------------------------------------------------
// noisy_label_hinge_loss_core_tb
// Drives label beats into the hinge cost core: a short directed set covering
// score extremes, held-back top positives, ties and flag changes, then random
// rows and batches under both clean_mode settings and one long row with
// held-back positives. Both channels idle at random; one phase stalls the
// result side long enough to back up the input.
// ----------------------------------------------------------------------------
module noisy_label_hinge_loss_core_tb;
  import nlhl_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int TAIL_CYCLES  = 60;    // covers the back end's batch-end division
  localparam int PHASE_LABELS = 45;
  localparam int LONG_ROW     = 1030;  // past 1024 labels

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_data;
  int   errors;
  int   pending;

  // Pacing controls for sender and receiver
  bit   tx_steady;
  bit   rx_steady;
  int   rx_hold_cycles;
  int   labels_sent;

  nlhl_in_if  in_ch ();
  nlhl_out_if out_ch ();

  noisy_label_hinge_loss_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  noisy_label_hinge_loss_checker cost_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_mon   (in_ch),
    .out_mon  (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Wait in cycles before a beat; zero about a third of the time
  function automatic int draw_wait();
    return ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 14));
  endfunction

  function automatic logic signed [15:0] draw_score();
    int v;
    case ($urandom_range(0, 7))
      0: v = $urandom_range(0, 1) ? 32767 : -32768;
      1: v = ($urandom_range(0, 1) ? 4096 : -4096) + int'($urandom_range(0, 2)) - 1;
      2: begin
        // small pool so positives tie often
        case ($urandom_range(0, 3))
          0: v = -2048;
          1: v = 0;
          2: v = 1024;
          default: v = 4095;
        endcase
      end
      3, 4: v = int'($urandom_range(0, 12000)) - 6000;
      default: v = int'($urandom_range(0, 65535));
    endcase
    return 16'(v);
  endfunction

  // Result side: per beat random hold-off, or a long hold when requested
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        gap = rx_steady ? 0 : draw_wait();
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // One label beat; returns at the edge that accepts it
  task automatic send_label(input logic signed [15:0] score,
                            input logic positive, clean, row_end, batch_end);
    int gap;
    gap = tx_steady ? 0 : draw_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.score         <= score;
    in_ch.is_positive   <= positive;
    in_ch.row_clean     <= clean;
    in_ch.last_in_row   <= row_end;
    in_ch.last_in_batch <= batch_end;
    do @(posedge clk); while (!in_ch.ready);
    labels_sent++;
  endtask

  // Random row; row_clean flips now and then, stray batch marks mid-row
  task automatic send_row(input int len, input bit batch_end);
    bit clean;
    bit mark;
    clean = 1'($urandom_range(0, 1));
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) clean = ~clean;
      mark = (i == len - 1) ? batch_end : ($urandom_range(0, 3) == 0);
      send_label(draw_score(), 1'($urandom_range(0, 1)), clean, i == len - 1, mark);
    end
  endtask

  // Block idle: all results back, then the back end's latency
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_clean_mode(input logic mode);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic run_random_batches(input int n_labels);
    int start;
    int rows;
    int len;
    start = labels_sent;
    while (labels_sent - start < n_labels) begin
      rows = $urandom_range(1, 5);
      for (int r = 0; r < rows; r++) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        send_row(len, r == rows - 1);
      end
    end
  endtask

  initial begin
    in_ch.valid         <= 1'b0;
    in_ch.score         <= '0;
    in_ch.is_positive   <= 1'b0;
    in_ch.row_clean     <= 1'b0;
    in_ch.last_in_row   <= 1'b0;
    in_ch.last_in_batch <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_data            <= 1'b0;
    rst_n               <= 1'b0;
    tx_steady      = 1'b0;
    rx_steady      = 1'b0;
    rx_hold_cycles = 0;
    labels_sent    = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: term extremes, every term kind, stray batch mark
    write_clean_mode(1'b0);
    send_label(-16'sd32768, 1'b0, 1'b0, 1'b0, 1'b1);
    send_label(-16'sd4096,  1'b0, 1'b0, 1'b0, 1'b0);
    send_label(-16'sd4095,  1'b0, 1'b0, 1'b0, 1'b0);
    send_label(16'sd32767,  1'b0, 1'b0, 1'b0, 1'b0);
    send_label(16'sd4096,   1'b1, 1'b0, 1'b0, 1'b0);
    send_label(16'sd4095,   1'b1, 1'b0, 1'b0, 1'b0);
    send_label(-16'sd32768, 1'b1, 1'b0, 1'b0, 1'b0);
    send_label(16'sd32767,  1'b1, 1'b0, 1'b1, 1'b1);

    // Noisy rows: held top positive with a tie, no positives,
    // flags changing mid-row, clean row, single held positive
    write_clean_mode(1'b1);
    send_label(16'sd100,    1'b1, 1'b0, 1'b0, 1'b0);
    send_label(16'sd300,    1'b1, 1'b0, 1'b0, 1'b0);
    send_label(16'sd300,    1'b1, 1'b0, 1'b0, 1'b0);
    send_label(16'sd0,      1'b0, 1'b0, 1'b0, 1'b0);
    send_label(-16'sd300,   1'b1, 1'b0, 1'b1, 1'b0);
    send_label(16'sd5,      1'b0, 1'b0, 1'b0, 1'b0);
    send_label(-16'sd5,     1'b0, 1'b0, 1'b1, 1'b0);
    send_label(16'sd200,    1'b1, 1'b0, 1'b0, 1'b0);
    send_label(16'sd500,    1'b1, 1'b1, 1'b0, 1'b0);
    send_label(16'sd100,    1'b1, 1'b0, 1'b0, 1'b0);
    send_label(-16'sd100,   1'b1, 1'b1, 1'b1, 1'b0);
    send_label(16'sd1000,   1'b1, 1'b1, 1'b0, 1'b0);
    send_label(16'sd2000,   1'b1, 1'b1, 1'b1, 1'b0);
    send_label(-16'sd32768, 1'b1, 1'b0, 1'b1, 1'b1);

    // Random phases over both modes and pacing styles
    for (int p = 0; p < 6; p++) begin
      write_clean_mode((p == 1 || p == 3) ? 1'b0 : 1'b1);
      tx_steady = (p == 1 || p == 2 || p == 5);
      rx_steady = (p == 1 || p == 5);
      // result side stalls long while beats keep coming
      if (p == 2) rx_hold_cycles = 400;
      run_random_batches(PHASE_LABELS);
    end
    tx_steady = 1'b1;
    rx_steady = 1'b1;

    // Long row with held-back positives, closing its batch
    write_clean_mode(1'b1);
    for (int i = 0; i < LONG_ROW; i++) begin
      if (i % 100 == 50)
        send_label(-16'sd1000, 1'b1, 1'b0, 1'b0, 1'b0);
      else
        send_label(16'sd32767, 1'b0, 1'b0, i == LONG_ROW - 1, i == LONG_ROW - 1);
    end

    wait_idle();
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/nlhl_pkg.sv
hw/rtl/nlhl_if.sv
hw/rtl/nlhl_front.sv
hw/rtl/nlhl_queue.sv
hw/rtl/nlhl_back.sv
hw/rtl/noisy_label_hinge_loss_core.sv
dv/noisy_label_hinge_loss_checker.sv
dv/noisy_label_hinge_loss_core_tb.sv
